FILE: rtl/core/sgcs_pkg.sv
// Shared types, constants and arithmetic helpers of the sand grid cell step unit.
`timescale 1ns / 1ps
`default_nettype none
package sgcs_pkg;

  // grid geometry; cell address is {row, column}
  localparam int MAX_W      = 64;
  localparam int MAX_H      = 64;
  localparam int COL_BITS   = $clog2(MAX_W);
  localparam int ROW_BITS   = $clog2(MAX_H);
  localparam int ADDR_BITS  = COL_BITS + ROW_BITS;
  localparam int CELLS      = MAX_W * MAX_H;

  // damping factor 0.99 in Q0.16, move threshold 1.0 in Q8.8
  localparam logic [17:0]        DAMP_Q16 = 18'd64881;
  localparam logic signed [15:0] MOVE_EPS = 16'sd256;

  // commands
  localparam logic [2:0] CMD_CLEAR   = 3'd0;
  localparam logic [2:0] CMD_PASS    = 3'd1;
  localparam logic [2:0] CMD_INTEG   = 3'd2;
  localparam logic [2:0] CMD_TRY     = 3'd3;
  localparam logic [2:0] CMD_REPLACE = 3'd4;
  localparam logic [2:0] CMD_READ    = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_HEIGHT  = 3'd1;
  localparam logic [2:0] CFG_CLEAR   = 3'd2;
  localparam logic [2:0] CFG_GRAV_X  = 3'd3;
  localparam logic [2:0] CFG_GRAV_Y  = 3'd4;

  typedef struct packed {
    logic [7:0]        age;
    logic [7:0]        kind;
    logic [7:0]        mass;
    logic signed [15:0] vy;
    logic signed [15:0] vx;
  } grain_t;

  // one neighbor probe: offsets, axis (1 = y) and negative normal
  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
    logic              axis;
    logic              neg;
  } nb_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISP, S_PASS_MX, S_PASS_RX, S_PASS_MY, S_PASS_RY,
    S_GCHK, S_SET, S_PCHK, S_ADD, S_DMX, S_DRX, S_DMY, S_DRY, S_CLS,
    S_NRD, S_NCHK, S_MV1, S_MV2, S_MV3, S_CMUL, S_DLD, S_DIV, S_CADD,
    S_CWR, S_WB, S_FIN
  } state_t;

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    logic signed [15:0] r;
    if (v > 40'sd32767)       r = 16'sh7fff;
    else if (v < -40'sd32768) r = 16'sh8000;
    else                      r = v[15:0];
    return r;
  endfunction

  // round to nearest, ties away from zero, by 2^8 or 2^16
  function automatic logic signed [39:0] rnd_shr(input logic signed [35:0] p,
                                                 input logic sel16);
    logic [35:0] mag;
    logic [35:0] r;
    mag = p[35] ? 36'(-p) : 36'(p);
    r   = sel16 ? ((mag + 36'd32768) >> 16) : ((mag + 36'd128) >> 8);
    return p[35] ? -$signed({4'b0, r}) : $signed({4'b0, r});
  endfunction

  // motion region from damped velocity
  function automatic logic [3:0] classify(input logic signed [15:0] vx,
                                          input logic signed [15:0] vy);
    logic [3:0] r;
    if (vy > MOVE_EPS)
      r = (vx > MOVE_EPS) ? 4'd3 : ((vx < -MOVE_EPS) ? 4'd1 : 4'd2);
    else if (vy < -MOVE_EPS)
      r = (vx > MOVE_EPS) ? 4'd5 : ((vx < -MOVE_EPS) ? 4'd7 : 4'd6);
    else if (vx > MOVE_EPS)  r = 4'd4;
    else if (vx < -MOVE_EPS) r = 4'd8;
    else                     r = 4'd0;
    return r;
  endfunction

  function automatic logic [1:0] nb_count(input logic [3:0] region);
    logic [1:0] c;
    if (region == 4'd0 || region > 4'd8) c = 2'd0;
    else if (region[0])                  c = 2'd3;
    else                                 c = 2'd1;
    return c;
  endfunction

  // neighbor probe order per region: {dx, dy, axis, neg}
  function automatic nb_t nb_lookup(input logic [3:0] region, input logic [1:0] idx);
    logic [5:0] c;
    case ({region, idx})
      {4'd1, 2'd0}: c = 6'b11_11_1_1;
      {4'd1, 2'd1}: c = 6'b00_11_1_1;
      {4'd1, 2'd2}: c = 6'b11_00_0_0;
      {4'd2, 2'd0}: c = 6'b00_11_1_1;
      {4'd3, 2'd0}: c = 6'b00_11_1_1;
      {4'd3, 2'd1}: c = 6'b01_11_1_1;
      {4'd3, 2'd2}: c = 6'b01_00_0_1;
      {4'd4, 2'd0}: c = 6'b01_00_0_1;
      {4'd5, 2'd0}: c = 6'b01_00_0_1;
      {4'd5, 2'd1}: c = 6'b00_01_1_0;
      {4'd5, 2'd2}: c = 6'b01_01_1_0;
      {4'd6, 2'd0}: c = 6'b00_01_1_0;
      {4'd7, 2'd0}: c = 6'b11_00_0_0;
      {4'd7, 2'd1}: c = 6'b11_01_1_0;
      {4'd7, 2'd2}: c = 6'b00_01_1_0;
      {4'd8, 2'd0}: c = 6'b11_00_0_0;
      default:      c = 6'b00_00_0_0;
    endcase
    return nb_t'(c);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sand_grid_cell_step_unit.sv
// Sand grid cell step unit: grain and pixel stores under one command sequencer.
//
//  channel  ports                                         direction
//  command  start, busy, in_cmd .. in_pass_dt             in (start/busy)
//  result   out_strobe, out_ok, out_moved, out_pixel       out, one cycle
//  config   cfg_we, cfg_index, cfg_data                   in, no wait
//
// Integrate adds gravity, damps and classifies the velocity, then walks the
// neighbor probes of its region: a skipped probe moves on, a move ends the
// command, and a collision takes one or two rounds through the shared 18x18
// multiplier and the 25-step restoring divider. Clear and reset sweep both
// stores one cell a cycle; a reset sweep reports no result.
// Results cannot be stalled; each appears for one cycle as busy drops.
`timescale 1ns / 1ps
`default_nettype none
module sand_grid_cell_step_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [5:0]  in_cell_x,
  input  wire logic [5:0]  in_cell_y,
  input  wire logic [7:0]  in_grain_kind,
  input  wire logic [7:0]  in_grain_mass,
  input  wire logic [31:0] in_grain_color,
  input  wire logic [15:0] in_pass_dt,
  output logic             out_strobe,
  output logic             out_ok,
  output logic             out_moved,
  output logic [31:0]      out_pixel,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int AW = sgcs_pkg::ADDR_BITS;
  localparam logic signed [17:0] DAMP_B = $signed(sgcs_pkg::DAMP_Q16);

  // configuration
  logic [6:0]         grid_w_r, grid_h_r;
  logic [31:0]        clear_color_r;
  logic signed [15:0] grav_x_r, grav_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r      <= 7'd64;
      grid_h_r      <= 7'd64;
      clear_color_r <= '0;
      grav_x_r      <= '0;
      grav_y_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sgcs_pkg::CFG_WIDTH:  grid_w_r      <= cfg_data[6:0];
        sgcs_pkg::CFG_HEIGHT: grid_h_r      <= cfg_data[6:0];
        sgcs_pkg::CFG_CLEAR:  clear_color_r <= cfg_data;
        sgcs_pkg::CFG_GRAV_X: grav_x_r      <= cfg_data[15:0];
        sgcs_pkg::CFG_GRAV_Y: grav_y_r      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [6:0] eff_w, eff_h;
  assign eff_w = (grid_w_r > 7'(sgcs_pkg::MAX_W)) ? 7'(sgcs_pkg::MAX_W) : grid_w_r;
  assign eff_h = (grid_h_r > 7'(sgcs_pkg::MAX_H)) ? 7'(sgcs_pkg::MAX_H) : grid_h_r;

  // sequencer and datapath registers
  sgcs_pkg::state_t state_r, state_nxt;

  logic [2:0]  cmd_r;
  logic [5:0]  x_r, y_r;
  logic [7:0]  kind_r, mass_r;
  logic [31:0] color_r;
  logic [15:0] dt_r;

  logic [7:0]         pass_age_r;
  logic signed [15:0] gsx_r, gsy_r;

  sgcs_pkg::grain_t g_r, n_r;
  logic [3:0]         region_r;
  logic [1:0]         idx_r;
  logic               axis_r, nin_r, phase_r;
  logic [AW-1:0]      naddr_r;
  logic signed [15:0] va_r, vb_r;
  logic signed [16:0] vrel_r;
  logic [7:0]         mb_r;
  logic signed [35:0] prod_r;
  logic [24:0]        dvn_r;
  logic [8:0]         rem_r, den_r;
  logic [4:0]         dcnt_r;
  logic [AW-1:0]      sweep_r;
  logic [31:0]        sweep_color_r;
  logic               clr_report_r;
  logic               ok_r, moved_r;
  logic [31:0]        pix_r;

  // memories
  sgcs_pkg::grain_t g_mem [sgcs_pkg::CELLS];
  logic [31:0]      p_mem [sgcs_pkg::CELLS];
  logic             g_we, p_we;
  logic [AW-1:0]    g_wa, g_ra, p_wa, p_ra;
  sgcs_pkg::grain_t g_wd, g_rd_q;
  logic [31:0]      p_wd, p_rd_q;

  always_ff @(posedge clk) begin
    if (g_we) g_mem[g_wa] <= g_wd;
    g_rd_q <= g_mem[g_ra];
  end

  always_ff @(posedge clk) begin
    if (p_we) p_mem[p_wa] <= p_wd;
    p_rd_q <= p_mem[p_ra];
  end

  // addressed cell and current neighbor probe
  logic [AW-1:0]      caddr;
  logic               cell_in;
  sgcs_pkg::nb_t      nbi;
  logic signed [7:0]  nx_s, ny_s;
  logic               nb_in;
  logic [1:0]         nb_cnt;

  assign caddr   = {y_r, x_r};
  assign cell_in = ({1'b0, x_r} < eff_w) && ({1'b0, y_r} < eff_h);
  assign nbi     = sgcs_pkg::nb_lookup(region_r, idx_r);
  assign nx_s    = $signed({2'b00, x_r}) + $signed({{6{nbi.dx[1]}}, nbi.dx});
  assign ny_s    = $signed({2'b00, y_r}) + $signed({{6{nbi.dy[1]}}, nbi.dy});
  assign nb_in   = !nx_s[7] && !ny_s[7] && (nx_s[6:0] < eff_w) && (ny_s[6:0] < eff_h);
  assign nb_cnt  = sgcs_pkg::nb_count(region_r);

  // collision terms from the freshly read neighbor
  logic signed [15:0] va_c, vb_c;
  logic signed [16:0] diff_c, vrel_c;
  logic [7:0]         mb_c;
  assign va_c   = axis_r ? g_r.vy : g_r.vx;
  assign vb_c   = nin_r ? (axis_r ? g_rd_q.vy : g_rd_q.vx) : 16'sd0;
  assign mb_c   = nin_r ? g_rd_q.mass : 8'd0;
  assign diff_c = 17'(vb_c) - 17'(va_c);
  assign vrel_c = nbi.neg ? -diff_c : diff_c;

  // divider step
  logic [9:0] trial;
  logic       qbit;
  assign trial = {rem_r, dvn_r[24]};
  assign qbit  = (trial >= {1'b0, den_r});

  logic signed [39:0] qsum;
  assign qsum = (phase_r ? 40'(vb_r) : 40'(va_r)) + $signed({15'b0, dvn_r});

  // shared multiplier operands
  logic signed [17:0] mul_a, mul_b;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sgcs_pkg::S_CLEAR:
        if (sweep_r == AW'(sgcs_pkg::CELLS - 1))
          state_nxt = clr_report_r ? sgcs_pkg::S_FIN : sgcs_pkg::S_IDLE;
      sgcs_pkg::S_IDLE:    if (start) state_nxt = sgcs_pkg::S_DISP;
      sgcs_pkg::S_DISP: begin
        unique case (cmd_r)
          sgcs_pkg::CMD_CLEAR: state_nxt = sgcs_pkg::S_CLEAR;
          sgcs_pkg::CMD_PASS:  state_nxt = sgcs_pkg::S_PASS_MX;
          sgcs_pkg::CMD_INTEG, sgcs_pkg::CMD_TRY, sgcs_pkg::CMD_REPLACE:
            state_nxt = cell_in ? sgcs_pkg::S_GCHK : sgcs_pkg::S_FIN;
          sgcs_pkg::CMD_READ:
            state_nxt = cell_in ? sgcs_pkg::S_PCHK : sgcs_pkg::S_FIN;
          default:             state_nxt = sgcs_pkg::S_FIN;
        endcase
      end
      sgcs_pkg::S_PASS_MX: state_nxt = sgcs_pkg::S_PASS_RX;
      sgcs_pkg::S_PASS_RX: state_nxt = sgcs_pkg::S_PASS_MY;
      sgcs_pkg::S_PASS_MY: state_nxt = sgcs_pkg::S_PASS_RY;
      sgcs_pkg::S_PASS_RY: state_nxt = sgcs_pkg::S_FIN;
      sgcs_pkg::S_GCHK: begin
        unique case (cmd_r)
          sgcs_pkg::CMD_INTEG:
            state_nxt = (g_rd_q.mass == 8'd0 || g_rd_q.age == pass_age_r) ?
                        sgcs_pkg::S_FIN : sgcs_pkg::S_ADD;
          sgcs_pkg::CMD_TRY:
            state_nxt = (g_rd_q.kind == 8'd0) ? sgcs_pkg::S_SET : sgcs_pkg::S_FIN;
          default: state_nxt = sgcs_pkg::S_SET;
        endcase
      end
      sgcs_pkg::S_SET:     state_nxt = sgcs_pkg::S_FIN;
      sgcs_pkg::S_PCHK:    state_nxt = sgcs_pkg::S_FIN;
      sgcs_pkg::S_ADD:     state_nxt = sgcs_pkg::S_DMX;
      sgcs_pkg::S_DMX:     state_nxt = sgcs_pkg::S_DRX;
      sgcs_pkg::S_DRX:     state_nxt = sgcs_pkg::S_DMY;
      sgcs_pkg::S_DMY:     state_nxt = sgcs_pkg::S_DRY;
      sgcs_pkg::S_DRY:     state_nxt = sgcs_pkg::S_CLS;
      sgcs_pkg::S_CLS:     state_nxt = sgcs_pkg::S_NRD;
      sgcs_pkg::S_NRD:
        state_nxt = (idx_r == nb_cnt) ? sgcs_pkg::S_WB : sgcs_pkg::S_NCHK;
      sgcs_pkg::S_NCHK: begin
        if (nin_r && g_rd_q.kind == 8'd0) state_nxt = sgcs_pkg::S_MV1;
        else if (vrel_c <= 17'sd0)        state_nxt = sgcs_pkg::S_NRD;
        else                              state_nxt = sgcs_pkg::S_CMUL;
      end
      sgcs_pkg::S_MV1:     state_nxt = sgcs_pkg::S_MV2;
      sgcs_pkg::S_MV2:     state_nxt = sgcs_pkg::S_MV3;
      sgcs_pkg::S_MV3:     state_nxt = sgcs_pkg::S_FIN;
      sgcs_pkg::S_CMUL:    state_nxt = sgcs_pkg::S_DLD;
      sgcs_pkg::S_DLD:     state_nxt = sgcs_pkg::S_DIV;
      sgcs_pkg::S_DIV:     if (dcnt_r == 5'd24) state_nxt = sgcs_pkg::S_CADD;
      sgcs_pkg::S_CADD:
        state_nxt = (!phase_r && mb_r != 8'd0) ? sgcs_pkg::S_CMUL : sgcs_pkg::S_CWR;
      sgcs_pkg::S_CWR:     state_nxt = sgcs_pkg::S_NRD;
      sgcs_pkg::S_WB:      state_nxt = sgcs_pkg::S_FIN;
      sgcs_pkg::S_FIN:     state_nxt = sgcs_pkg::S_IDLE;
      default:             state_nxt = sgcs_pkg::S_IDLE;
    endcase
  end

  // memory ports and multiplier operands per state
  always_comb begin
    g_we  = 1'b0;
    g_wa  = caddr;
    g_wd  = g_r;
    g_ra  = caddr;
    p_we  = 1'b0;
    p_wa  = caddr;
    p_wd  = clear_color_r;
    p_ra  = caddr;
    mul_a = 18'(g_r.vx);
    mul_b = DAMP_B;
    unique case (state_r)
      sgcs_pkg::S_CLEAR: begin
        g_we = 1'b1;
        g_wa = sweep_r;
        g_wd = '0;
        p_we = 1'b1;
        p_wa = sweep_r;
        p_wd = sweep_color_r;
      end
      sgcs_pkg::S_SET: begin
        g_we = 1'b1;
        g_wd = '{age: g_r.age, kind: kind_r, mass: mass_r, vy: 16'sd0, vx: 16'sd0};
        p_we = 1'b1;
        p_wd = (kind_r == 8'd0) ? clear_color_r : color_r;
      end
      sgcs_pkg::S_PASS_MX: begin
        mul_a = 18'(grav_x_r);
        mul_b = $signed({2'b00, dt_r});
      end
      sgcs_pkg::S_PASS_MY: begin
        mul_a = 18'(grav_y_r);
        mul_b = $signed({2'b00, dt_r});
      end
      sgcs_pkg::S_DMY: mul_a = 18'(g_r.vy);
      sgcs_pkg::S_NRD: g_ra = {ny_s[5:0], nx_s[5:0]};
      sgcs_pkg::S_MV1: begin
        g_we = 1'b1;
        g_wa = naddr_r;
        g_wd = '{age: pass_age_r, kind: g_r.kind, mass: g_r.mass, vy: g_r.vy, vx: g_r.vx};
      end
      sgcs_pkg::S_MV2: begin
        g_we = 1'b1;
        g_wd = '0;
        p_we = 1'b1;
        p_wa = naddr_r;
        p_wd = p_rd_q;
      end
      sgcs_pkg::S_MV3: p_we = 1'b1;
      sgcs_pkg::S_CMUL: begin
        mul_a = 18'(vrel_r);
        mul_b = $signed({10'b0, (phase_r ? g_r.mass : mb_r)});
      end
      sgcs_pkg::S_CWR: begin
        g_we = nin_r;
        g_wa = naddr_r;
        g_wd = axis_r ? '{age: n_r.age, kind: n_r.kind, mass: n_r.mass, vy: vb_r, vx: n_r.vx}
                      : '{age: n_r.age, kind: n_r.kind, mass: n_r.mass, vy: n_r.vy, vx: vb_r};
      end
      sgcs_pkg::S_WB: begin
        g_we = 1'b1;
        g_wd = '{age: pass_age_r, kind: g_r.kind, mass: g_r.mass, vy: g_r.vy, vx: g_r.vx};
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= sgcs_pkg::S_CLEAR;
      sweep_r       <= '0;
      sweep_color_r <= '0;
      clr_report_r  <= 1'b0;
      pass_age_r    <= '0;
      gsx_r         <= '0;
      gsy_r         <= '0;
      out_strobe    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_strobe <= (state_r == sgcs_pkg::S_FIN);
      if (state_r == sgcs_pkg::S_CLEAR) sweep_r <= sweep_r + AW'(1);
      if (state_r == sgcs_pkg::S_DISP && cmd_r == sgcs_pkg::CMD_CLEAR) begin
        sweep_r       <= '0;
        sweep_color_r <= clear_color_r;
        clr_report_r  <= 1'b1;
        pass_age_r    <= '0;
      end
      if (state_r == sgcs_pkg::S_DISP && cmd_r == sgcs_pkg::CMD_PASS)
        pass_age_r <= pass_age_r + 8'd1;
      if (state_r == sgcs_pkg::S_PASS_RX) gsx_r <= sgcs_pkg::sat16(sgcs_pkg::rnd_shr(prod_r, 1'b0));
      if (state_r == sgcs_pkg::S_PASS_RY) gsy_r <= sgcs_pkg::sat16(sgcs_pkg::rnd_shr(prod_r, 1'b0));
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (state_r == sgcs_pkg::S_FIN) begin
      out_ok    <= ok_r;
      out_moved <= moved_r;
      out_pixel <= pix_r;
    end
    case (state_r)
      sgcs_pkg::S_CLEAR: begin
        ok_r    <= 1'b1;
        moved_r <= 1'b0;
        pix_r   <= '0;
      end
      sgcs_pkg::S_IDLE: begin
        cmd_r   <= in_cmd;
        x_r     <= in_cell_x;
        y_r     <= in_cell_y;
        kind_r  <= in_grain_kind;
        mass_r  <= in_grain_mass;
        color_r <= in_grain_color;
        dt_r    <= in_pass_dt;
      end
      sgcs_pkg::S_DISP: begin
        ok_r    <= (cmd_r == sgcs_pkg::CMD_REPLACE || cmd_r == sgcs_pkg::CMD_PASS);
        moved_r <= 1'b0;
        pix_r   <= '0;
      end
      sgcs_pkg::S_GCHK: begin
        g_r <= g_rd_q;
        if (cmd_r != sgcs_pkg::CMD_TRY || g_rd_q.kind == 8'd0) ok_r <= 1'b1;
      end
      sgcs_pkg::S_PCHK: begin
        ok_r  <= 1'b1;
        pix_r <= p_rd_q;
      end
      sgcs_pkg::S_ADD: begin
        g_r.vx <= sgcs_pkg::sat16(40'(g_r.vx) + 40'(gsx_r));
        g_r.vy <= sgcs_pkg::sat16(40'(g_r.vy) + 40'(gsy_r));
      end
      sgcs_pkg::S_DRX: g_r.vx <= sgcs_pkg::sat16(sgcs_pkg::rnd_shr(prod_r, 1'b1));
      sgcs_pkg::S_DRY: g_r.vy <= sgcs_pkg::sat16(sgcs_pkg::rnd_shr(prod_r, 1'b1));
      sgcs_pkg::S_CLS: begin
        region_r <= sgcs_pkg::classify(g_r.vx, g_r.vy);
        idx_r    <= '0;
      end
      sgcs_pkg::S_NRD: begin
        naddr_r <= {ny_s[5:0], nx_s[5:0]};
        nin_r   <= nb_in;
        axis_r  <= nbi.axis;
      end
      sgcs_pkg::S_NCHK: begin
        n_r     <= g_rd_q;
        va_r    <= va_c;
        vb_r    <= vb_c;
        mb_r    <= mb_c;
        vrel_r  <= vrel_c;
        phase_r <= 1'b0;
        // a skipped probe moves on to the next neighbor
        if (!(nin_r && g_rd_q.kind == 8'd0) && vrel_c <= 17'sd0) idx_r <= idx_r + 2'd1;
      end
      sgcs_pkg::S_MV3: moved_r <= 1'b1;
      sgcs_pkg::S_DLD: begin
        dvn_r  <= prod_r[24:0] + 25'({1'b0, g_r.mass} + {1'b0, mb_r}) / 25'd2;
        den_r  <= {1'b0, g_r.mass} + {1'b0, mb_r};
        rem_r  <= '0;
        dcnt_r <= '0;
      end
      sgcs_pkg::S_DIV: begin
        rem_r  <= qbit ? 9'(trial - {1'b0, den_r}) : trial[8:0];
        dvn_r  <= {dvn_r[23:0], qbit};
        dcnt_r <= dcnt_r + 5'd1;
      end
      sgcs_pkg::S_CADD: begin
        if (phase_r) vb_r <= sgcs_pkg::sat16(qsum);
        else         va_r <= sgcs_pkg::sat16(qsum);
        phase_r <= 1'b1;
      end
      sgcs_pkg::S_CWR: begin
        if (axis_r) g_r.vy <= va_r;
        else        g_r.vx <= va_r;
        idx_r <= idx_r + 2'd1;
      end
      default: ;
    endcase
  end

  assign busy = (state_r != sgcs_pkg::S_IDLE);

  // checks
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted command did not raise busy");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("result shown while busy");
  a_moved_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_moved) |-> out_ok) else $error("move reported without ok");
  a_pixel_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_pixel != 32'd0) |-> out_ok) else $error("pixel without ok");

endmodule
`default_nettype wire
